@@ hw/rtl/tvad_pkg.sv @@
// Shared constants, types and the arctangent table for the target view angle pipeline.
// No dependencies; imported by target_view_angle_and_distance.
package tvad_pkg;

    localparam int FIELD_W    = 32;            // one Q16.16 coordinate
    localparam int IN_TDATA_W = 9 * FIELD_W;   // nine coordinates
    localparam int OUT_TDATA_W = 48;           // angle (16) and distance (32)

    localparam int SQ1_BITS = 34;              // root bits of a 68-bit sum of squares
    localparam int SQ1_W    = 2 * SQ1_BITS;
    localparam int DOT_W    = 67;              // magnitude of a sum of three 65-bit products
    localparam int NUM_W    = DOT_W + 30;      // dot magnitude scaled to Q1.30
    localparam int PROD_W   = 2 * SQ1_BITS;    // product of the two lengths
    localparam int DIV_W    = PROD_W + 32;     // widest shifted divisor
    localparam int Q_BITS   = 32;              // quotient bits; the quotient stays below 2^32
    localparam int SQ2_BITS = 31;              // root bits of a value below 2^61
    localparam int SQ2_W    = 2 * SQ2_BITS;
    localparam int XY_W     = 34;
    localparam int Z_W      = 26;
    localparam int CORDIC_STEPS = 23;

    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [15:0] ANGLE_MAX = 16'd46080;
    localparam logic [15:0] MIN_LENGTH_RESET = 16'd1;
    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90 * 65536);

    // Values that ride along the tail of the pipeline with each transaction.
    typedef struct packed {
        logic        ok;
        logic        neg;
        logic [31:0] distance;
    } side_t;

    // Arctangent of 2^-i in degrees, Q16.16.
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/target_view_angle_and_distance.sv @@
// Target view angle and distance: fully pipelined top level.
// Depends on tvad_pkg for widths, the side-band struct and the arctangent table.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------------
//  s_       | in        | tdata: cam_x,cam_y,cam_z,fwd_x,fwd_y,fwd_z,tgt_x,tgt_y,tgt_z
//  m_       | out       | tdata: angle_deg, distance; tuser: ok
//  cfg_     | in        | wdata: min_length (write-only register)
//
// One transaction enters per clock and one leaves per clock once the pipeline is full,
// while m_tready does not hold the output. The pipeline depth is set by the two bit-per-stage
// square root chains (34 and 31 stages), the bit-per-stage divider (32 stages) and the 23 CORDIC stages.
// Reset (aresetn low, synchronous) clears every stage valid bit and sets min_length to 1.
// When the output transaction is held by m_tready low, every stage holds; s_tready
// drops in the same cycle, so nothing is lost or repeated.
module target_view_angle_and_distance
    import tvad_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,     // min_length, Q16.16 fraction units
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata from bit 0 up: cam_x, cam_y, cam_z, fwd_x, fwd_y, fwd_z, tgt_x, tgt_y, tgt_z
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata from bit 0 up: angle_deg[15:0], distance[31:0]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser from bit 0 up: ok
    output logic [0:0]             m_tuser
);

    // The whole pipeline advances together whenever the output register is free.
    logic adv;
    logic m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic m_ok_reg, m_ok_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_ok_reg;

    logic [15:0] min_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= MIN_LENGTH_RESET;
        end else if (cfg_we) begin
            min_length_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: difference vector target minus camera, forward vector.
    // ---------------------------------------------------------------------
    logic               v1_reg;
    logic signed [32:0] d_reg [3], d_next [3];
    logic signed [31:0] f_reg [3], f_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_next[i] = $signed({s_tdata[(6+i)*FIELD_W+FIELD_W-1], s_tdata[(6+i)*FIELD_W +: FIELD_W]})
                      - $signed({s_tdata[i*FIELD_W+FIELD_W-1], s_tdata[i*FIELD_W +: FIELD_W]});
            f_next[i] = $signed(s_tdata[(3+i)*FIELD_W +: FIELD_W]);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: the nine products on magnitudes, with the sign of each cross term.
    // ---------------------------------------------------------------------
    logic        v2_reg;
    logic [65:0] dd_reg [3], dd_next [3];
    logic [63:0] ff_reg [3], ff_next [3];
    logic [64:0] df_reg [3], df_next [3];
    logic        dfn_reg [3], dfn_next [3];

    always_comb begin
        logic [32:0] dm;
        logic [31:0] fm;
        for (int i = 0; i < 3; i++) begin
            dm = d_reg[i][32] ? 33'(-d_reg[i]) : 33'(d_reg[i]);
            fm = f_reg[i][31] ? 32'(-f_reg[i]) : 32'(f_reg[i]);
            dd_next[i]  = dm * dm;
            ff_next[i]  = fm * fm;
            df_next[i]  = dm * fm;
            dfn_next[i] = d_reg[i][32] ^ f_reg[i][31];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: squared lengths and the dot product split by sign.
    // ---------------------------------------------------------------------
    logic             v3_reg;
    logic [SQ1_W-1:0] ld2_reg, ld2_next, lf2_reg, lf2_next;
    logic [DOT_W-1:0] pos_reg, pos_next, neg_reg, neg_next;

    always_comb begin
        ld2_next = SQ1_W'(dd_reg[0]) + SQ1_W'(dd_reg[1]) + SQ1_W'(dd_reg[2]);
        lf2_next = SQ1_W'(ff_reg[0]) + SQ1_W'(ff_reg[1]) + SQ1_W'(ff_reg[2]);
        pos_next = '0;
        neg_next = '0;
        for (int i = 0; i < 3; i++) begin
            if (dfn_reg[i]) begin
                neg_next = neg_next + DOT_W'(df_reg[i]);
            end else begin
                pos_next = pos_next + DOT_W'(df_reg[i]);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Square roots of both squared lengths, one root bit per stage.
    // Index 0 loads the operands and the signed dot magnitude.
    // ---------------------------------------------------------------------
    logic             s1_vld_reg [SQ1_BITS+1];
    logic [SQ1_W-1:0] sd_v_reg [SQ1_BITS+1], sd_v_next [SQ1_BITS+1];
    logic [SQ1_W-1:0] sd_r_reg [SQ1_BITS+1], sd_r_next [SQ1_BITS+1];
    logic [SQ1_W-1:0] sf_v_reg [SQ1_BITS+1], sf_v_next [SQ1_BITS+1];
    logic [SQ1_W-1:0] sf_r_reg [SQ1_BITS+1], sf_r_next [SQ1_BITS+1];
    logic [DOT_W-1:0] m1_reg [SQ1_BITS+1], m1_next [SQ1_BITS+1];
    logic             n1_reg [SQ1_BITS+1], n1_next [SQ1_BITS+1];

    always_comb begin
        logic [SQ1_W-1:0] one, td, tf;
        sd_v_next[0] = ld2_reg;
        sd_r_next[0] = '0;
        sf_v_next[0] = lf2_reg;
        sf_r_next[0] = '0;
        n1_next[0]   = neg_reg > pos_reg;
        m1_next[0]   = (neg_reg > pos_reg) ? neg_reg - pos_reg : pos_reg - neg_reg;
        for (int k = 0; k < SQ1_BITS; k++) begin
            one = SQ1_W'(1) << (2 * (SQ1_BITS - 1 - k));
            td  = sd_r_reg[k] + one;
            tf  = sf_r_reg[k] + one;
            if (sd_v_reg[k] >= td) begin
                sd_v_next[k+1] = sd_v_reg[k] - td;
                sd_r_next[k+1] = (sd_r_reg[k] >> 1) + one;
            end else begin
                sd_v_next[k+1] = sd_v_reg[k];
                sd_r_next[k+1] = sd_r_reg[k] >> 1;
            end
            if (sf_v_reg[k] >= tf) begin
                sf_v_next[k+1] = sf_v_reg[k] - tf;
                sf_r_next[k+1] = (sf_r_reg[k] >> 1) + one;
            end else begin
                sf_v_next[k+1] = sf_v_reg[k];
                sf_r_next[k+1] = sf_r_reg[k] >> 1;
            end
            m1_next[k+1] = m1_reg[k];
            n1_next[k+1] = n1_reg[k];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: degenerate test, saturated distance, partial products of
    // the length product (a 34 by 34 product split at bit 32).
    // ---------------------------------------------------------------------
    logic             v5_reg;
    side_t            sd5_reg, sd5_next;
    logic [63:0]      p00_reg, p00_next;
    logic [33:0]      p01_reg, p01_next, p10_reg, p10_next;
    logic [3:0]       p11_reg, p11_next;
    logic [NUM_W-1:0] num_reg, num_next;

    always_comb begin
        logic [SQ1_BITS-1:0] ld, lf;
        ld = sd_r_reg[SQ1_BITS][SQ1_BITS-1:0];
        lf = sf_r_reg[SQ1_BITS][SQ1_BITS-1:0];
        sd5_next.ok   = (ld > SQ1_BITS'(min_length_reg)) && (lf > SQ1_BITS'(min_length_reg));
        sd5_next.neg  = n1_reg[SQ1_BITS];
        sd5_next.distance = (ld[33:32] != 2'b00) ? 32'hFFFF_FFFF : ld[31:0];
        p00_next = lf[31:0] * ld[31:0];
        p01_next = lf[31:0] * ld[33:32];
        p10_next = lf[33:32] * ld[31:0];
        p11_next = lf[33:32] * ld[33:32];
        num_next = {m1_reg[SQ1_BITS], 30'b0};
    end

    // ---------------------------------------------------------------------
    // Divider: quotient of the Q1.30-scaled dot magnitude by the length
    // product, one quotient bit per stage. Index 0 loads the operands.
    // ---------------------------------------------------------------------
    logic              dv_vld_reg [Q_BITS+1];
    side_t             dv_sd_reg [Q_BITS+1], dv_sd_next [Q_BITS+1];
    logic [PROD_W-1:0] dv_p_reg [Q_BITS+1], dv_p_next [Q_BITS+1];
    logic [NUM_W-1:0]  dv_rem_reg [Q_BITS+1], dv_rem_next [Q_BITS+1];
    logic [Q_BITS-1:0] dv_q_reg [Q_BITS+1], dv_q_next [Q_BITS+1];

    always_comb begin
        logic [DIV_W-1:0] trial;
        dv_sd_next[0]  = sd5_reg;
        dv_p_next[0]   = PROD_W'(p00_reg) + (PROD_W'(p01_reg) << 32)
                       + (PROD_W'(p10_reg) << 32) + (PROD_W'(p11_reg) << 64);
        dv_rem_next[0] = num_reg;
        dv_q_next[0]   = '0;
        for (int k = 0; k < Q_BITS; k++) begin
            trial = DIV_W'(dv_p_reg[k]) << (Q_BITS - 1 - k);
            dv_sd_next[k+1]  = dv_sd_reg[k];
            dv_p_next[k+1]   = dv_p_reg[k];
            dv_q_next[k+1]   = dv_q_reg[k];
            dv_rem_next[k+1] = dv_rem_reg[k];
            if (DIV_W'(dv_rem_reg[k]) >= trial) begin
                dv_rem_next[k+1] = dv_rem_reg[k] - trial[NUM_W-1:0];
                dv_q_next[k+1][Q_BITS-1-k] = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 7: clamp the cosine magnitude to one. Stage 8: its square.
    // ---------------------------------------------------------------------
    logic        v7_reg, v8_reg;
    side_t       sd7_reg, sd7_next, sd8_reg;
    logic [30:0] cm7_reg, cm7_next, cm8_reg;
    logic [61:0] cmsq_reg, cmsq_next;

    always_comb begin
        sd7_next  = dv_sd_reg[Q_BITS];
        cm7_next  = (dv_q_reg[Q_BITS] > 32'(ONE_Q30)) ? ONE_Q30 : dv_q_reg[Q_BITS][30:0];
        cmsq_next = cm7_reg * cm7_reg;
    end

    // ---------------------------------------------------------------------
    // Sine: square root of one minus the squared cosine, one bit per stage.
    // ---------------------------------------------------------------------
    logic             s2_vld_reg [SQ2_BITS+1];
    side_t            s2_sd_reg [SQ2_BITS+1], s2_sd_next [SQ2_BITS+1];
    logic [30:0]      s2_cm_reg [SQ2_BITS+1], s2_cm_next [SQ2_BITS+1];
    logic [SQ2_W-1:0] s2_v_reg [SQ2_BITS+1], s2_v_next [SQ2_BITS+1];
    logic [SQ2_W-1:0] s2_r_reg [SQ2_BITS+1], s2_r_next [SQ2_BITS+1];

    always_comb begin
        logic [SQ2_W-1:0] one, t;
        s2_sd_next[0] = sd8_reg;
        s2_cm_next[0] = cm8_reg;
        s2_v_next[0]  = (SQ2_W'(1) << 60) - cmsq_reg;
        s2_r_next[0]  = '0;
        for (int k = 0; k < SQ2_BITS; k++) begin
            one = SQ2_W'(1) << (2 * (SQ2_BITS - 1 - k));
            t   = s2_r_reg[k] + one;
            s2_sd_next[k+1] = s2_sd_reg[k];
            s2_cm_next[k+1] = s2_cm_reg[k];
            if (s2_v_reg[k] >= t) begin
                s2_v_next[k+1] = s2_v_reg[k] - t;
                s2_r_next[k+1] = (s2_r_reg[k] >> 1) + one;
            end else begin
                s2_v_next[k+1] = s2_v_reg[k];
                s2_r_next[k+1] = s2_r_reg[k] >> 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // CORDIC vectoring of (cos, sin). A negative cosine is first turned by
    // a quarter turn so the steps only cover the right half plane.
    // ---------------------------------------------------------------------
    logic                  c_vld_reg [CORDIC_STEPS+1];
    side_t                 c_sd_reg [CORDIC_STEPS+1], c_sd_next [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] c_x_reg [CORDIC_STEPS+1], c_x_next [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] c_y_reg [CORDIC_STEPS+1], c_y_next [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  c_z_reg [CORDIC_STEPS+1], c_z_next [CORDIC_STEPS+1];

    always_comb begin
        logic signed [XY_W-1:0] cpos, spos, xs, ys;
        logic signed [Z_W-1:0]  at;
        cpos = $signed(XY_W'(s2_cm_reg[SQ2_BITS]));
        spos = $signed(XY_W'(s2_r_reg[SQ2_BITS][SQ2_BITS-1:0]));
        c_sd_next[0] = s2_sd_reg[SQ2_BITS];
        if (s2_sd_reg[SQ2_BITS].neg && cpos != '0) begin
            c_x_next[0] = spos;
            c_y_next[0] = cpos;
            c_z_next[0] = Z_QUARTER;
        end else begin
            c_x_next[0] = cpos;
            c_y_next[0] = spos;
            c_z_next[0] = '0;
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            xs = c_x_reg[k] >>> k;
            ys = c_y_reg[k] >>> k;
            at = $signed(Z_W'(atan_deg(5'(k))));
            c_sd_next[k+1] = c_sd_reg[k];
            if (!c_y_reg[k][XY_W-1]) begin
                c_x_next[k+1] = c_x_reg[k] + ys;
                c_y_next[k+1] = c_y_reg[k] - xs;
                c_z_next[k+1] = c_z_reg[k] + at;
            end else begin
                c_x_next[k+1] = c_x_reg[k] - ys;
                c_y_next[k+1] = c_y_reg[k] + xs;
                c_z_next[k+1] = c_z_reg[k] - at;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register: round Q16.16 degrees to Q8.8 and clamp to 180.
    // A degenerate transaction reports zero angle and zero distance.
    // ---------------------------------------------------------------------
    always_comb begin
        logic [Z_W-1:0] zc;
        logic [Z_W-1:0] zr;
        logic [15:0]    ang;
        side_t          sd;
        sd  = c_sd_reg[CORDIC_STEPS];
        zc  = c_z_reg[CORDIC_STEPS][Z_W-1] ? '0 : Z_W'(c_z_reg[CORDIC_STEPS]);
        zr  = (zc + Z_W'(128)) >> 8;
        ang = (zr > Z_W'(ANGLE_MAX)) ? ANGLE_MAX : zr[15:0];
        m_ok_next    = sd.ok;
        m_tdata_next = sd.ok ? {sd.distance, ang} : '0;
    end

    // Valid bits: cleared by reset, shifted whenever the pipeline advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v5_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k <= SQ1_BITS; k++) s1_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= Q_BITS; k++) dv_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= SQ2_BITS; k++) s2_vld_reg[k] <= 1'b0;
            for (int k = 0; k <= CORDIC_STEPS; k++) c_vld_reg[k] <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            s1_vld_reg[0] <= v3_reg;
            for (int k = 0; k < SQ1_BITS; k++) s1_vld_reg[k+1] <= s1_vld_reg[k];
            v5_reg <= s1_vld_reg[SQ1_BITS];
            dv_vld_reg[0] <= v5_reg;
            for (int k = 0; k < Q_BITS; k++) dv_vld_reg[k+1] <= dv_vld_reg[k];
            v7_reg <= dv_vld_reg[Q_BITS];
            v8_reg <= v7_reg;
            s2_vld_reg[0] <= v8_reg;
            for (int k = 0; k < SQ2_BITS; k++) s2_vld_reg[k+1] <= s2_vld_reg[k];
            c_vld_reg[0] <= s2_vld_reg[SQ2_BITS];
            for (int k = 0; k < CORDIC_STEPS; k++) c_vld_reg[k+1] <= c_vld_reg[k];
            m_tvalid_reg <= c_vld_reg[CORDIC_STEPS];
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg   <= d_next;
            f_reg   <= f_next;
            dd_reg  <= dd_next;
            ff_reg  <= ff_next;
            df_reg  <= df_next;
            dfn_reg <= dfn_next;
            ld2_reg <= ld2_next;
            lf2_reg <= lf2_next;
            pos_reg <= pos_next;
            neg_reg <= neg_next;
            sd_v_reg <= sd_v_next;
            sd_r_reg <= sd_r_next;
            sf_v_reg <= sf_v_next;
            sf_r_reg <= sf_r_next;
            m1_reg  <= m1_next;
            n1_reg  <= n1_next;
            sd5_reg <= sd5_next;
            p00_reg <= p00_next;
            p01_reg <= p01_next;
            p10_reg <= p10_next;
            p11_reg <= p11_next;
            num_reg <= num_next;
            dv_sd_reg  <= dv_sd_next;
            dv_p_reg   <= dv_p_next;
            dv_rem_reg <= dv_rem_next;
            dv_q_reg   <= dv_q_next;
            sd7_reg  <= sd7_next;
            cm7_reg  <= cm7_next;
            sd8_reg  <= sd7_reg;
            cm8_reg  <= cm7_reg;
            cmsq_reg <= cmsq_next;
            s2_sd_reg <= s2_sd_next;
            s2_cm_reg <= s2_cm_next;
            s2_v_reg  <= s2_v_next;
            s2_r_reg  <= s2_r_next;
            c_sd_reg <= c_sd_next;
            c_x_reg  <= c_x_next;
            c_y_reg  <= c_y_next;
            c_z_reg  <= c_z_next;
            m_tdata_reg <= m_tdata_next;
            m_ok_reg    <= m_ok_next;
        end
    end

    // A degenerate result carries an all-zero payload.
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate transaction with nonzero payload");

    // The angle never exceeds 180 degrees.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:0] <= ANGLE_MAX)
        else $error("angle out of range");

    // A transaction that passed the length test never divides by zero.
    a_nonzero_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_vld_reg[0] && dv_sd_reg[0].ok |-> dv_p_reg[0] != '0)
        else $error("zero length product on a valid transaction");

    // A new output only appears when the last CORDIC stage held one.
    a_output_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(c_vld_reg[CORDIC_STEPS]))
        else $error("output valid without a finished transaction");

endmodule
